### rtl/core/fbc_pkg.sv
// fbc_pkg: shared constants, plane type and plane builder for the frustum box cull core
// depends on nothing; used by the box interface, the cells, the register block and the top level
`default_nettype none

package fbc_pkg;

  // default coordinate width, signed Q16.8
  localparam int COORD_WIDTH_DEF = 24;
  localparam int COORD_FRAC      = 8;

  // matrix entries are signed Q4.12, planes carry one extra bit for the exact sum
  localparam int ENTRY_W    = 16;
  localparam int PLANE_W    = ENTRY_W + 1;
  localparam int ROW_W      = 4 * ENTRY_W;
  localparam int NUM_ROWS   = 4;
  localparam int NUM_PLANES = 6;
  localparam int NUM_AXES   = 3;

  // configuration port
  localparam int CFG_DATA_W = ROW_W;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 2;
  localparam int REG_LSB    = 3;

  localparam logic [REG_IDX_W-1:0] REG_ROW0 = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW1 = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROW2 = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROW3 = 2'd3;

  // identity matrix after reset
  localparam logic [ROW_W-1:0] ROW0_RESET = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW1_RESET = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW2_RESET = 64'h0000_1000_0000_0000;
  localparam logic [ROW_W-1:0] ROW3_RESET = 64'h1000_0000_0000_0000;

  // one clip plane: normal components and offset, 12 fraction bits, two's complement
  typedef struct packed {
    logic [NUM_AXES-1:0][PLANE_W-1:0] n;
    logic [PLANE_W-1:0]               d;
  } plane_t;

  // plane = base row plus or minus another row, entry by entry
  function automatic plane_t plane_of(input logic [ROW_W-1:0] base,
                                      input logic [ROW_W-1:0] row,
                                      input logic             sub);
    plane_t             p;
    logic [PLANE_W-1:0] ea;
    logic [PLANE_W-1:0] eb;
    logic [PLANE_W-1:0] comp;
    p = '0;
    for (int k = 0; k < 4; k++) begin
      ea   = {base[k*ENTRY_W+ENTRY_W-1], base[k*ENTRY_W +: ENTRY_W]};
      eb   = {row[k*ENTRY_W+ENTRY_W-1], row[k*ENTRY_W +: ENTRY_W]};
      comp = sub ? (ea - eb) : (ea + eb);
      if (k < NUM_AXES) begin
        p.n[k] = comp;
      end else begin
        p.d = comp;
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

### rtl/core/fbc_box_if.sv
// fbc_box_if: valid/ready channel carrying one axis-aligned box request
// depends on fbc_pkg for the default coordinate width
`default_nettype none

interface fbc_box_if #(
  parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] min_x;
  logic signed [COORD_WIDTH-1:0] min_y;
  logic signed [COORD_WIDTH-1:0] min_z;
  logic signed [COORD_WIDTH-1:0] max_x;
  logic signed [COORD_WIDTH-1:0] max_y;
  logic signed [COORD_WIDTH-1:0] max_z;
  logic                          box_valid;

  modport source (
    output valid, min_x, min_y, min_z, max_x, max_y, max_z, box_valid,
    input  ready
  );

  modport sink (
    input  valid, min_x, min_y, min_z, max_x, max_y, max_z, box_valid,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/fbc_vis_if.sv
// fbc_vis_if: valid/ready channel carrying one visibility result request
// standalone, no package dependency
`default_nettype none

interface fbc_vis_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (
    output valid, visible,
    input  ready
  );

  modport sink (
    input  valid, visible,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/fbc_cfg_regs.sv
// fbc_cfg_regs: apb-style register block holding the four view-projection matrix rows
// depends on fbc_pkg for widths, register indexes and reset values
`default_nettype none

module fbc_cfg_regs (
  input  wire logic                                            clk,
  input  wire logic                                            rst,
  input  wire logic                                            psel,
  input  wire logic                                            penable,
  input  wire logic                                            pwrite,
  input  wire logic [fbc_pkg::CFG_ADDR_W-1:0]                  paddr,
  input  wire logic [fbc_pkg::CFG_DATA_W-1:0]                  pwdata,
  output logic      [fbc_pkg::CFG_DATA_W-1:0]                  prdata,
  output logic                                                 pready,
  output logic      [fbc_pkg::NUM_ROWS-1:0][fbc_pkg::ROW_W-1:0] rows
);

  logic                          wr_en;
  logic [fbc_pkg::REG_IDX_W-1:0] reg_idx;

  // register index from the 8-byte aligned address
  assign reg_idx = paddr[fbc_pkg::CFG_ADDR_W-1:fbc_pkg::REG_LSB];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // matrix rows, identity after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0] <= fbc_pkg::ROW0_RESET;
      rows[1] <= fbc_pkg::ROW1_RESET;
      rows[2] <= fbc_pkg::ROW2_RESET;
      rows[3] <= fbc_pkg::ROW3_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        fbc_pkg::REG_ROW0: rows[0] <= pwdata;
        fbc_pkg::REG_ROW1: rows[1] <= pwdata;
        fbc_pkg::REG_ROW2: rows[2] <= pwdata;
        fbc_pkg::REG_ROW3: rows[3] <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      fbc_pkg::REG_ROW0: prdata = rows[0];
      fbc_pkg::REG_ROW1: prdata = rows[1];
      fbc_pkg::REG_ROW2: prdata = rows[2];
      fbc_pkg::REG_ROW3: prdata = rows[3];
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/fbc_cell.sv
// fbc_cell: one clip-plane test cell, two stages, box and running verdict handed to the next cell
// depends on fbc_pkg for the plane type and fixed-point constants
`default_nettype none

module fbc_cell #(
  parameter  int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF,
  localparam int BoxW        = 6 * COORD_WIDTH + 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire fbc_pkg::plane_t plane_in,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [BoxW-1:0] box_in,
  input  wire logic            vis_in,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic      [BoxW-1:0] box_out,
  output logic                 vis_out
);

  localparam int PlaneW = fbc_pkg::PLANE_W;
  localparam int ProdW  = PlaneW + COORD_WIDTH;
  localparam int DtermW = PlaneW + fbc_pkg::COORD_FRAC;
  localparam int SumW   = ProdW + 2;
  localparam int Axes   = fbc_pkg::NUM_AXES;

  fbc_pkg::plane_t                plane_q;
  logic                           v1;
  logic                           v2;
  logic [BoxW-1:0]                box1;
  logic [BoxW-1:0]                box2;
  logic                           vis1;
  logic                           vis2;
  logic                           load1;
  logic                           load2;
  logic signed [ProdW-1:0]        prod_next [Axes];
  logic signed [ProdW-1:0]        prod2 [Axes];
  logic signed [DtermW-1:0]       dterm;
  logic signed [SumW-1:0]         plane_dist;

  // stall chain: a stage loads when empty or when it moves on
  assign load2    = ~v2 | out_ready;
  assign load1    = ~v1 | load2;
  assign in_ready = load1;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (load1) begin
        v1 <= in_valid;
      end
      if (load2) begin
        v2 <= v1;
      end
    end
  end

  // local copy of this cell's plane
  always_ff @(posedge clk) begin
    plane_q <= plane_in;
  end

  // positive vertex per axis and its product with the normal component
  always_comb begin
    logic signed [ProdW-1:0] n_ext;
    logic signed [ProdW-1:0] c_ext;
    logic [COORD_WIDTH-1:0]  coord;
    for (int k = 0; k < Axes; k++) begin
      coord = plane_q.n[k][PlaneW-1] ? box1[k*COORD_WIDTH +: COORD_WIDTH]
                                     : box1[(k+3)*COORD_WIDTH +: COORD_WIDTH];
      n_ext = {{COORD_WIDTH{plane_q.n[k][PlaneW-1]}}, plane_q.n[k]};
      c_ext = {{PlaneW{coord[COORD_WIDTH-1]}}, coord};
      prod_next[k] = n_ext * c_ext;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (load1) begin
      box1 <= box_in;
      vis1 <= vis_in;
    end
    if (load2) begin
      box2 <= box1;
      vis2 <= vis1;
      for (int k = 0; k < Axes; k++) begin
        prod2[k] <= prod_next[k];
      end
    end
  end

  // signed distance of the positive vertex, offset scaled to product fraction bits
  assign dterm      = {plane_q.d, {fbc_pkg::COORD_FRAC{1'b0}}};
  assign plane_dist = SumW'(prod2[0]) + SumW'(prod2[1]) + SumW'(prod2[2]) + SumW'(dterm);

  // an invalid box keeps its verdict, otherwise a negative distance culls it
  assign out_valid = v2;
  assign box_out   = box2;
  assign vis_out   = vis2 & (~box2[BoxW-1] | ~plane_dist[SumW-1]);

endmodule

`default_nettype wire

### rtl/core/frustum_box_cull_core.sv
// frustum_box_cull_core: view-frustum culling of axis-aligned boxes against six clip planes
// depends on fbc_pkg, fbc_box_if, fbc_vis_if, fbc_cfg_regs and fbc_cell
// pipeline: a box request passes six cells, two stages each, and then a final output register;
// throughput is one box per cycle while the result side does not stall, set by the cell chain
// stall: each stage loads when empty or moving on, so bubbles close up behind a stalled output
// reset: synchronous, clears all valid bits and loads the identity matrix into the rows
`default_nettype none

module frustum_box_cull_core #(
  parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [fbc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [fbc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [fbc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                  pready,
  fbc_box_if.sink                               box,
  fbc_vis_if.source                             result
);

  localparam int BoxW   = 6 * COORD_WIDTH + 1;
  localparam int Planes = fbc_pkg::NUM_PLANES;

  logic [fbc_pkg::NUM_ROWS-1:0][fbc_pkg::ROW_W-1:0] rows;
  logic                                             link_valid [Planes+1];
  logic                                             link_ready [Planes+1];
  logic [BoxW-1:0]                                  link_box   [Planes+1];
  logic                                             link_vis   [Planes+1];
  logic                                             res_valid;
  logic                                             res_visible;
  logic                                             load_o;

  // matrix registers
  fbc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rows    (rows)
  );

  // box request enters the chain, verdict starts as visible
  assign link_valid[0] = box.valid;
  assign box.ready     = link_ready[0];
  assign link_box[0]   = {box.box_valid, box.max_z, box.max_y, box.max_x,
                          box.min_z, box.min_y, box.min_x};
  assign link_vis[0]   = 1'b1;

  // one cell per clip plane: row3 + row r, then row3 - row r
  for (genvar p = 0; p < Planes; p++) begin : g_cell
    fbc_pkg::plane_t plane;
    assign plane = fbc_pkg::plane_of(rows[3], rows[p / 2], 1'(p % 2));

    fbc_cell #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .plane_in  (plane),
      .in_valid  (link_valid[p]),
      .in_ready  (link_ready[p]),
      .box_in    (link_box[p]),
      .vis_in    (link_vis[p]),
      .out_valid (link_valid[p+1]),
      .out_ready (link_ready[p+1]),
      .box_out   (link_box[p+1]),
      .vis_out   (link_vis[p+1])
    );
  end

  // output register
  assign load_o             = ~res_valid | result.ready;
  assign link_ready[Planes] = load_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_o) begin
      res_valid <= link_valid[Planes];
    end
  end

  always_ff @(posedge clk) begin
    if (load_o) begin
      res_visible <= link_vis[Planes];
    end
  end

  assign result.valid   = res_valid;
  assign result.visible = res_visible;

  // the input side only stalls when every stage is full behind a stalled result
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !box.ready |-> (result.valid && !result.ready))
    else $error("box request refused while the chain can still move");

  // reset leaves no result pending
  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");

  // a row 3 write lands in the plane source
  a_row3_write: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite
     && paddr[fbc_pkg::CFG_ADDR_W-1:fbc_pkg::REG_LSB] == fbc_pkg::REG_ROW3)
    |=> rows[3] == $past(pwdata))
    else $error("matrix row 3 write lost");

endmodule

`default_nettype wire
